// ===== design/plist_pkg.sv =====
// plist_pkg: shared types, codes and widths for the positional list engine.
// No dependencies; imported by plist_ctrl, plist_dpath, positional_list_engine and tb_top.

package plist_pkg;

	localparam int CAPACITY_DEF = 64;
	localparam int REQ_W = 3;
	localparam int POS_W = 6;
	localparam int KEY_W = 31;
	localparam int PAY_W = 64;
	localparam int CNT_W = 7;
	localparam int ST_W  = 3;

	typedef enum logic [REQ_W-1:0] {
		REQ_INS_FRONT = 3'd0,
		REQ_INS_END   = 3'd1,
		REQ_INS_AT    = 3'd2,
		REQ_DEL_FRONT = 3'd3,
		REQ_DEL_END   = 3'd4,
		REQ_DEL_AT    = 3'd5,
		REQ_FIND      = 3'd6
	} req_code_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK       = 3'd0,
		ST_EMPTY    = 3'd1,
		ST_FULL     = 3'd2,
		ST_BADPOS   = 3'd3,
		ST_NOTFOUND = 3'd4
	} status_t;

	typedef struct packed {
		logic [REQ_W-1:0] req_type;
		logic [POS_W-1:0] position;
		logic [KEY_W-1:0] key;
		logic [PAY_W-1:0] payload;
	} req_t;

	typedef struct packed {
		logic [ST_W-1:0]  status;
		logic [POS_W-1:0] found_position;
		logic [KEY_W-1:0] entry_key;
		logic [PAY_W-1:0] entry_payload;
		logic [CNT_W-1:0] entry_count;
	} rsp_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [PAY_W-1:0] payload;
	} entry_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_INS_SHIFT,
		S_INS_DRAIN,
		S_INS_PUT,
		S_DEL_CAP,
		S_DEL_SHIFT,
		S_DEL_DRAIN,
		S_FIND
	} state_t;

	typedef enum logic [2:0] {
		PTR_HOLD,
		PTR_LOAD_AT,
		PTR_LOAD_TOP,
		PTR_LOAD_ZERO,
		PTR_INC,
		PTR_DEC
	} ptr_op_t;

	typedef enum logic [1:0] {
		POS_ZERO,
		POS_AT,
		POS_IDX
	} pos_sel_t;

	typedef enum logic [1:0] {
		ENT_ZERO,
		ENT_HELD,
		ENT_RDATA
	} ent_sel_t;

	typedef enum logic [1:0] {
		CNT_HOLD,
		CNT_INC,
		CNT_DEC
	} cnt_op_t;

	typedef struct packed {
		logic     latch;
		ptr_op_t  ptr_op;
		logic     shift_rd;
		logic     shift_up;
		logic     cmp_rd;
		logic     cap_rd;
		logic     put_new;
		logic     finish;
		status_t  fin_status;
		pos_sel_t pos_sel;
		ent_sel_t ent_sel;
		cnt_op_t  cnt_op;
	} cmd_t;

	typedef struct packed {
		logic [REQ_W-1:0] req_type;
		logic             full;
		logic             empty;
		logic             badpos;
		logic             noshift;
		logic             ptr_eq_at;
		logic             ptr_eq_top;
		logic             cmp_hit;
		logic             cmp_last;
	} dp_sts_t;

endpackage

// ===== design/plist_ctrl.sv =====
// plist_ctrl: request sequencer for the positional list engine.
// Depends on plist_pkg; drives plist_dpath through cmd_t and reads dp_sts_t.

module plist_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  plist_pkg::dp_sts_t sts,
	output plist_pkg::cmd_t    cmd
);
	import plist_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) state_d = S_DECODE;
			end
			S_DECODE: begin
				case (sts.req_type) inside
					REQ_INS_FRONT, REQ_INS_END, REQ_INS_AT: begin
						if (sts.full || sts.badpos) state_d = S_IDLE;
						else if (sts.noshift) state_d = S_INS_PUT;
						else state_d = S_INS_SHIFT;
					end
					REQ_DEL_FRONT, REQ_DEL_END, REQ_DEL_AT: begin
						if (sts.empty || sts.badpos) state_d = S_IDLE;
						else state_d = S_DEL_CAP;
					end
					REQ_FIND: begin
						if (sts.empty) state_d = S_IDLE;
						else state_d = S_FIND;
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_INS_SHIFT: begin
				if (sts.ptr_eq_at) state_d = S_INS_DRAIN;
			end
			S_INS_DRAIN: state_d = S_INS_PUT;
			S_INS_PUT:   state_d = S_IDLE;
			S_DEL_CAP: begin
				state_d = sts.noshift ? S_DEL_DRAIN : S_DEL_SHIFT;
			end
			S_DEL_SHIFT: begin
				if (sts.ptr_eq_top) state_d = S_DEL_DRAIN;
			end
			S_DEL_DRAIN: state_d = S_IDLE;
			S_FIND: begin
				if (sts.cmp_hit || sts.cmp_last) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd            = '0;
		cmd.ptr_op     = PTR_HOLD;
		cmd.fin_status = ST_OK;
		cmd.pos_sel    = POS_ZERO;
		cmd.ent_sel    = ENT_ZERO;
		cmd.cnt_op     = CNT_HOLD;
		unique case (state_q)
			S_IDLE: begin
				cmd.latch = start;
			end
			S_DECODE: begin
				case (sts.req_type) inside
					REQ_INS_FRONT, REQ_INS_END, REQ_INS_AT: begin
						if (sts.full) begin
							cmd.finish     = 1'b1;
							cmd.fin_status = ST_FULL;
						end else if (sts.badpos) begin
							cmd.finish     = 1'b1;
							cmd.fin_status = ST_BADPOS;
						end else if (!sts.noshift) begin
							cmd.ptr_op = PTR_LOAD_TOP;
						end
					end
					REQ_DEL_FRONT, REQ_DEL_END, REQ_DEL_AT: begin
						if (sts.empty) begin
							cmd.finish     = 1'b1;
							cmd.fin_status = ST_EMPTY;
						end else if (sts.badpos) begin
							cmd.finish     = 1'b1;
							cmd.fin_status = ST_BADPOS;
						end else begin
							cmd.ptr_op = PTR_LOAD_AT;
						end
					end
					REQ_FIND: begin
						if (sts.empty) begin
							cmd.finish     = 1'b1;
							cmd.fin_status = ST_EMPTY;
						end else begin
							cmd.ptr_op = PTR_LOAD_ZERO;
						end
					end
					default: cmd.finish = 1'b1;
				endcase
			end
			S_INS_SHIFT: begin
				cmd.shift_rd = 1'b1;
				cmd.shift_up = 1'b1;
				cmd.ptr_op   = PTR_DEC;
			end
			S_INS_DRAIN: begin
			end
			S_INS_PUT: begin
				cmd.put_new = 1'b1;
				cmd.finish  = 1'b1;
				cmd.pos_sel = POS_AT;
				cmd.cnt_op  = CNT_INC;
			end
			S_DEL_CAP: begin
				cmd.cap_rd = 1'b1;
				cmd.ptr_op = PTR_INC;
			end
			S_DEL_SHIFT: begin
				cmd.shift_rd = 1'b1;
				cmd.ptr_op   = PTR_INC;
			end
			S_DEL_DRAIN: begin
				cmd.finish  = 1'b1;
				cmd.pos_sel = POS_AT;
				cmd.ent_sel = ENT_HELD;
				cmd.cnt_op  = CNT_DEC;
			end
			S_FIND: begin
				cmd.cmp_rd = 1'b1;
				cmd.ptr_op = PTR_INC;
				if (sts.cmp_hit) begin
					cmd.finish  = 1'b1;
					cmd.pos_sel = POS_IDX;
					cmd.ent_sel = ENT_RDATA;
				end else if (sts.cmp_last) begin
					cmd.finish     = 1'b1;
					cmd.fin_status = ST_NOTFOUND;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== design/plist_dpath.sv =====
// plist_dpath: entry memory, pointer, count and result registers of the list engine.
// Depends on plist_pkg; commanded by plist_ctrl.

module plist_dpath #(
	parameter int CAPACITY = plist_pkg::CAPACITY_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  plist_pkg::req_t    request,
	input  plist_pkg::cmd_t    cmd,
	output plist_pkg::dp_sts_t sts,
	output logic               done,
	output plist_pkg::rsp_t    result
);
	import plist_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	entry_t mem [CAPACITY];
	entry_t rdata_q;
	entry_t ent_q;
	req_t   req_q;
	rsp_t   result_q;

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] ptr_q;
	logic [CNT_W-1:0] shaddr_s1;
	logic [CNT_W-1:0] idx_s1;
	logic             shv_s1;
	logic             cmpv_s1;
	logic             cap_s1;
	logic             done_q;

	logic [CNT_W-1:0] at;
	logic [CNT_W-1:0] top;
	logic [CNT_W-1:0] count_d;
	logic             is_ins;
	logic             is_del;
	entry_t           ent_out;
	logic [POS_W-1:0] pos_out;

	assign top    = count_q - CNT_W'(1);
	assign is_ins = (req_q.req_type == REQ_INS_FRONT) || (req_q.req_type == REQ_INS_END) ||
			(req_q.req_type == REQ_INS_AT);
	assign is_del = (req_q.req_type == REQ_DEL_FRONT) || (req_q.req_type == REQ_DEL_END) ||
			(req_q.req_type == REQ_DEL_AT);

	always_comb begin
		case (req_q.req_type)
			REQ_INS_END: at = count_q;
			REQ_DEL_END: at = top;
			REQ_INS_AT, REQ_DEL_AT: at = {1'b0, req_q.position};
			default: at = '0;
		endcase
	end

	always_comb begin
		sts            = '0;
		sts.req_type   = req_q.req_type;
		sts.full       = (count_q >= CNT_W'(CAPACITY));
		sts.empty      = (count_q == '0);
		sts.badpos     = is_ins ? (at > count_q) : (is_del && (at >= count_q));
		sts.noshift    = is_ins ? (at == count_q) : (at == top);
		sts.ptr_eq_at  = (ptr_q == at);
		sts.ptr_eq_top = (ptr_q == top);
		sts.cmp_hit    = cmpv_s1 && (rdata_q.key == req_q.key);
		sts.cmp_last   = cmpv_s1 && (idx_s1 == top);
	end

	always_ff @(posedge clk) begin
		if (shv_s1) begin
			mem[shaddr_s1[AW-1:0]] <= rdata_q;
		end else if (cmd.put_new) begin
			mem[at[AW-1:0]] <= '{key: req_q.key, payload: req_q.payload};
		end
		rdata_q <= mem[ptr_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) req_q <= request;
		if (cap_s1) ent_q <= rdata_q;
		shaddr_s1 <= cmd.shift_up ? (ptr_q + CNT_W'(1)) : (ptr_q - CNT_W'(1));
		idx_s1    <= ptr_q;
		if (cmd.finish) begin
			result_q.status         <= cmd.fin_status;
			result_q.found_position <= pos_out;
			result_q.entry_key      <= ent_out.key;
			result_q.entry_payload  <= ent_out.payload;
			result_q.entry_count    <= count_d;
		end
	end

	always_comb begin
		case (cmd.ptr_op)
			PTR_INC: count_d = count_q;
			default: count_d = count_q;
		endcase
		case (cmd.cnt_op)
			CNT_INC: count_d = count_q + CNT_W'(1);
			CNT_DEC: count_d = top;
			default: count_d = count_q;
		endcase
	end

	always_comb begin
		case (cmd.pos_sel)
			POS_AT:  pos_out = at[POS_W-1:0];
			POS_IDX: pos_out = idx_s1[POS_W-1:0];
			default: pos_out = '0;
		endcase
		case (cmd.ent_sel)
			ENT_HELD:  ent_out = cap_s1 ? rdata_q : ent_q;
			ENT_RDATA: ent_out = rdata_q;
			default:   ent_out = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ptr_q   <= '0;
			shv_s1  <= 1'b0;
			cmpv_s1 <= 1'b0;
			cap_s1  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			shv_s1  <= cmd.shift_rd;
			cmpv_s1 <= cmd.cmp_rd;
			cap_s1  <= cmd.cap_rd;
			done_q  <= cmd.finish;
			if (cmd.finish) count_q <= count_d;
			case (cmd.ptr_op)
				PTR_LOAD_AT:   ptr_q <= at;
				PTR_LOAD_TOP:  ptr_q <= top;
				PTR_LOAD_ZERO: ptr_q <= '0;
				PTR_INC:       ptr_q <= ptr_q + CNT_W'(1);
				PTR_DEC:       ptr_q <= ptr_q - CNT_W'(1);
				default:       ptr_q <= ptr_q;
			endcase
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

// ===== design/positional_list_engine.sv =====
// positional_list_engine: ordered key/payload list with insert, delete and find.
// Errors and unused codes finish in decode; insert moves entries a..top up one place,
// top first, then writes entry a; delete captures entry a and moves later ones down; find
// scans from entry 0 to a hit or the last entry. One request at a time: busy falls in the
// cycle of the done strobe; the time is set by the one-entry-per-cycle shift or scan.
// Reset clears the count and control; the entry memory is not cleared. No stall.

module positional_list_engine #(
	parameter int CAPACITY = plist_pkg::CAPACITY_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  plist_pkg::req_t request,
	output logic            done,
	output plist_pkg::rsp_t result
);
	import plist_pkg::*;

	cmd_t    cmd;
	dp_sts_t sts;

	plist_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	plist_dpath #(
		.CAPACITY (CAPACITY)
	) u_dpath (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (request),
		.cmd     (cmd),
		.sts     (sts),
		.done    (done),
		.result  (result)
	);

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without a transaction in progress");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted transaction did not raise busy");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.entry_count <= CNT_W'(CAPACITY)))
		else $error("entry count beyond capacity");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result.status == ST_EMPTY)) |-> (result.entry_count == '0))
		else $error("empty status with nonzero count");

endmodule

// ===== verif/tb_top.sv =====
// tb_top: self-checking testbench for positional_list_engine (insert, delete, find on a list).
// Depends on plist_pkg and the RTL. A queue-fed driver sends transactions, a local list model
// predicts each one, and a monitor compares every done strobe field by field.
`timescale 1ns / 100ps

module tb_top;
	import plist_pkg::*;

	localparam int CAP          = CAPACITY_DEF;
	localparam int N_RANDOM     = 600;
	localparam int DRAIN_CYCLES = 2 * CAP + 16;
	localparam int CYCLE_LIMIT  = 400000;

	localparam logic [REQ_W-1:0] REQ_UNUSED = 3'd7;

	localparam int MODE_FILL  = 0;
	localparam int MODE_MIX   = 1;
	localparam int MODE_DRAIN = 2;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic done;
	req_t request = '0;
	rsp_t result;

	positional_list_engine dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.done(done),
		.result(result)
	);

	logic [KEY_W-1:0] list_keys [CAP];
	logic [PAY_W-1:0] list_pays [CAP];
	int unsigned list_len = 0;

	req_t pending_reqs [$];
	rsp_t expected_rsps [$];
	int unsigned n_total = 0;
	int unsigned n_accepted = 0;
	int unsigned n_errors = 0;
	int unsigned n_random = 0;
	int unsigned gen_len = 0;
	int unsigned cycles = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	// list model: applies one request and returns the response it must produce
	function automatic rsp_t apply_request(req_t r);
		rsp_t o;
		int unsigned at;
		int unsigned i;
		o = '0;
		o.status = ST_OK;
		case (r.req_type)
			REQ_INS_FRONT, REQ_INS_END, REQ_INS_AT: begin
				at = (r.req_type == REQ_INS_FRONT) ? 0 :
					(r.req_type == REQ_INS_END) ? list_len : r.position;
				if (list_len >= CAP) begin
					o.status = ST_FULL;
				end else if (at > list_len) begin
					o.status = ST_BADPOS;
				end else begin
					for (i = list_len; i > at; i--) begin
						list_keys[i] = list_keys[i-1];
						list_pays[i] = list_pays[i-1];
					end
					list_keys[at] = r.key;
					list_pays[at] = r.payload;
					list_len++;
					o.found_position = POS_W'(at);
				end
			end
			REQ_DEL_FRONT, REQ_DEL_END, REQ_DEL_AT: begin
				if (list_len == 0) begin
					o.status = ST_EMPTY;
				end else begin
					at = (r.req_type == REQ_DEL_FRONT) ? 0 :
						(r.req_type == REQ_DEL_END) ? list_len - 1 : r.position;
					if (at >= list_len) begin
						o.status = ST_BADPOS;
					end else begin
						o.found_position = POS_W'(at);
						o.entry_key = list_keys[at];
						o.entry_payload = list_pays[at];
						for (i = at; i + 1 < list_len; i++) begin
							list_keys[i] = list_keys[i+1];
							list_pays[i] = list_pays[i+1];
						end
						list_len--;
					end
				end
			end
			REQ_FIND: begin
				if (list_len == 0) begin
					o.status = ST_EMPTY;
				end else begin
					o.status = ST_NOTFOUND;
					for (i = 0; i < list_len; i++) begin
						if (list_keys[i] == r.key) begin
							o.status = ST_OK;
							o.found_position = POS_W'(i);
							o.entry_key = list_keys[i];
							o.entry_payload = list_pays[i];
							break;
						end
					end
				end
			end
			default: begin
			end
		endcase
		o.entry_count = list_len[CNT_W-1:0];
		return o;
	endfunction

	// queues a transaction; gen_len follows the list length so positions stay mostly legal
	task automatic add_request(input logic [REQ_W-1:0] op, input logic [POS_W-1:0] pos,
			input logic [KEY_W-1:0] k, input logic [PAY_W-1:0] p);
		req_t r;
		int unsigned at;
		r.req_type = op;
		r.position = pos;
		r.key = k;
		r.payload = p;
		pending_reqs.push_back(r);
		n_total++;
		if (op == REQ_INS_FRONT || op == REQ_INS_END || op == REQ_INS_AT) begin
			at = (op == REQ_INS_FRONT) ? 0 : (op == REQ_INS_END) ? gen_len : pos;
			if (gen_len < CAP && at <= gen_len)
				gen_len++;
		end else if (op == REQ_DEL_FRONT || op == REQ_DEL_END ||
				(op == REQ_DEL_AT && pos < gen_len)) begin
			if (gen_len > 0)
				gen_len--;
		end
	endtask

	task automatic add_random(input int mode);
		int unsigned ins_pct, del_pct, find_pct, roll;
		logic [REQ_W-1:0] op;
		logic [POS_W-1:0] pos;
		logic [KEY_W-1:0] k;
		logic [PAY_W-1:0] p;
		case (mode)
			MODE_FILL: begin
				ins_pct = 80; del_pct = 10; find_pct = 8;
			end
			MODE_DRAIN: begin
				ins_pct = 10; del_pct = 75; find_pct = 13;
			end
			default: begin
				ins_pct = 38; del_pct = 38; find_pct = 22;
			end
		endcase
		roll = $urandom_range(0, 99);
		if (roll < ins_pct)
			op = REQ_W'($urandom_range(REQ_INS_FRONT, REQ_INS_AT));
		else if (roll < ins_pct + del_pct)
			op = REQ_W'($urandom_range(REQ_DEL_FRONT, REQ_DEL_AT));
		else if (roll < ins_pct + del_pct + find_pct)
			op = REQ_FIND;
		else
			op = REQ_UNUSED;
		if ($urandom_range(0, 99) < 85)
			pos = POS_W'($urandom_range(0, (gen_len < CAP) ? gen_len : CAP - 1));
		else
			pos = POS_W'($urandom());
		roll = $urandom_range(0, 99);
		if (roll < 50)
			k = KEY_W'($urandom_range(0, 15));
		else if (roll < 95)
			k = KEY_W'($urandom());
		else
			k = '1;
		if ($urandom_range(0, 99) < 95)
			p = {$urandom(), $urandom()};
		else
			p = '1;
		add_request(op, pos, k, p);
		if (op != REQ_UNUSED)
			n_random++;
	endtask

	function automatic void check_field(string name, logic [PAY_W-1:0] want,
			logic [PAY_W-1:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0h, actual %0h", name, want, got);
			n_errors++;
		end
	endfunction

	// driver: a held request may be withdrawn while busy, except while n_accepted is from 250 to 399
	always @(posedge clk) begin
		bit fire;
		bit hold_off;
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			fire = start && !busy;
			hold_off = !(n_accepted >= 250 && n_accepted < 400) && $urandom_range(0, 99) < 13;
			if (fire) begin
				expected_rsps.push_back(apply_request(request));
				n_accepted++;
			end
			if (start && !fire) begin
				if (hold_off) begin
					pending_reqs.push_front(request);
					start <= 1'b0;
				end
			end else if (pending_reqs.size() != 0 && !hold_off) begin
				request <= pending_reqs.pop_front();
				start <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && done === 1'b1) begin
			if (expected_rsps.size() == 0) begin
				$error("result transaction with nothing expected: status %0d count %0d",
					result.status, result.entry_count);
				n_errors++;
			end else begin
				want = expected_rsps.pop_front();
				check_field("status", PAY_W'(want.status), PAY_W'(result.status));
				check_field("found_position", PAY_W'(want.found_position),
					PAY_W'(result.found_position));
				check_field("entry_key", PAY_W'(want.entry_key), PAY_W'(result.entry_key));
				check_field("entry_payload", want.entry_payload, result.entry_payload);
				check_field("entry_count", PAY_W'(want.entry_count),
					PAY_W'(result.entry_count));
			end
		end
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$error("timeout: %0d of %0d transactions accepted, %0d results outstanding",
			n_accepted, n_total, expected_rsps.size());
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		int mode;
		// empty list: every delete and find, insert-at past the end
		add_request(REQ_DEL_FRONT, 6'd0, 31'd1, 64'd1);
		add_request(REQ_DEL_END, 6'd0, 31'd1, 64'd1);
		add_request(REQ_DEL_AT, 6'd0, 31'd1, 64'd1);
		add_request(REQ_FIND, 6'd0, 31'd0, 64'd0);
		add_request(REQ_INS_AT, 6'd1, 31'd9, 64'd9);
		add_request(REQ_INS_AT, 6'd63, 31'd9, 64'd9);
		add_request(REQ_INS_AT, 6'd0, 31'h7FFF_FFFF, '1);
		add_request(REQ_INS_FRONT, 6'd0, 31'd0, 64'd0);
		add_request(REQ_INS_END, 6'd0, 31'd5, 64'h0123_4567_89AB_CDEF);
		add_request(REQ_INS_AT, 6'd3, 31'h2AAA_AAAA, 64'hAAAA_AAAA_AAAA_AAAA);
		add_request(REQ_INS_AT, 6'd1, 31'h5555_5555, 64'h5555_5555_5555_5555);
		add_request(REQ_FIND, 6'd0, 31'h7FFF_FFFF, 64'd0);
		add_request(REQ_FIND, 6'd0, 31'd0, 64'd0);
		add_request(REQ_FIND, 6'd0, 31'd12345, 64'd0);
		add_request(REQ_DEL_AT, 6'd5, 31'd0, 64'd0);
		add_request(REQ_DEL_AT, 6'd63, 31'd0, 64'd0);
		add_request(REQ_UNUSED, 6'd63, '1, '1);
		add_request(REQ_DEL_AT, 6'd2, 31'd0, 64'd0);
		add_request(REQ_DEL_FRONT, 6'd0, 31'd0, 64'd0);
		add_request(REQ_DEL_END, 6'd0, 31'd0, 64'd0);
		add_request(REQ_INS_FRONT, 6'd0, 31'h7FFF_FFFF, 64'hFEED_0000_0000_0001);
		add_request(REQ_FIND, 6'd0, 31'h7FFF_FFFF, 64'd0);

		// random: fill to capacity and past it, mix, drain to empty and past it
		mode = MODE_FILL;
		while (n_random < N_RANDOM) begin
			if (mode == MODE_FILL) begin
				while (gen_len < CAP)
					add_random(mode);
				repeat ($urandom_range(4, 10)) add_random(mode);
			end else if (mode == MODE_DRAIN) begin
				while (gen_len > 0)
					add_random(mode);
				repeat ($urandom_range(4, 10)) add_random(mode);
			end else begin
				repeat ($urandom_range(30, 60)) add_random(mode);
			end
			mode = (mode + 1) % 3;
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		while (n_accepted < n_total || expected_rsps.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (n_errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== files.f =====
design/plist_pkg.sv
design/plist_ctrl.sv
design/plist_dpath.sv
design/positional_list_engine.sv
verif/tb_top.sv
